// ===== rtl/wft_pkg.sv =====
// Shared types and constants for the wildcard flow table.
// Used by wft_ctrl, wft_datapath and wildcard_flow_table_unit; no dependencies.
package wft_pkg;

    localparam int ENTRIES     = 64;
    localparam int IDX_W       = $clog2(ENTRIES);
    localparam int CMD_W       = 2;
    localparam int IP_W        = 32;
    localparam int L4_PORT_W   = 16;
    localparam int PROTO_W     = 8;
    localparam int ACTION_W    = 2;
    localparam int OUT_PORT_W  = 16;
    localparam int ENTRY_IDX_W = 6;

    localparam logic [IDX_W-1:0]     LAST_IDX   = IDX_W'(ENTRIES - 1);
    localparam logic [IP_W-1:0]      WILD_IP    = 32'hffff_ffff;
    localparam logic [L4_PORT_W-1:0] WILD_PORT  = 16'hffff;
    localparam logic [PROTO_W-1:0]   WILD_PROTO = 8'hff;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOOKUP    = 2'd0,
        CMD_INS_FRONT = 2'd1,
        CMD_INS_BACK  = 2'd2,
        CMD_NOP       = 2'd3
    } cmd_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_UNUSED  = 2'd0,
        ACT_FORWARD = 2'd1,
        ACT_REPLY   = 2'd2,
        ACT_DROP    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        RES_ZERO = 2'd0,
        RES_HIT  = 2'd1,
        RES_SLOT = 2'd2,
        RES_FULL = 2'd3
    } res_kind_t;

    // one table row as stored in the rule memory
    typedef struct packed {
        logic [IP_W-1:0]       src_ip;
        logic [IP_W-1:0]       dst_ip;
        logic [L4_PORT_W-1:0]  src_port;
        logic [L4_PORT_W-1:0]  dst_port;
        logic [PROTO_W-1:0]    protocol;
        logic [ACTION_W-1:0]   action;
        logic [OUT_PORT_W-1:0] port;
    } rule_t;

    // controller -> datapath
    typedef struct packed {
        logic      load;      // latch request word, restart scan
        logic      step;      // advance scan by one entry
        logic      write;     // write key into the free slot
        logic      capture;   // latch pending result
        res_kind_t res_kind;
        logic      push;      // move pending result to output register
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        cmd_t op;
        logic match;        // entry in read stage matches
        logic lookup_last;  // last entry is in read stage
        logic free;         // entry under insert pointer is unused
        logic ins_last;     // insert pointer on its last entry
    } dp_stat_t;

endpackage

// ===== rtl/wft_ctrl.sv =====
// Controller state machine for the wildcard flow table.
// Depends on wft_pkg; drives wft_datapath through dp_cmd_t.
module wft_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    input  wft_pkg::dp_stat_t stat,
    output wft_pkg::dp_cmd_t  cmd
);
    import wft_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_kind = RES_ZERO;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                case (stat.op)
                    CMD_LOOKUP:
                    begin
                        cmd.step = 1'b1;
                        if (stat.match)
                        begin
                            cmd.capture  = 1'b1;
                            cmd.res_kind = RES_HIT;
                            state_next   = ST_HOLD;
                        end
                        else if (stat.lookup_last)
                        begin
                            cmd.capture  = 1'b1;
                            cmd.res_kind = RES_ZERO;
                            state_next   = ST_HOLD;
                        end
                    end
                    CMD_INS_FRONT, CMD_INS_BACK:
                    begin
                        if (stat.free)
                        begin
                            cmd.write    = 1'b1;
                            cmd.capture  = 1'b1;
                            cmd.res_kind = RES_SLOT;
                            state_next   = ST_HOLD;
                        end
                        else if (stat.ins_last)
                        begin
                            cmd.capture  = 1'b1;
                            cmd.res_kind = RES_FULL;
                            state_next   = ST_HOLD;
                        end
                        else
                        begin
                            cmd.step = 1'b1;
                        end
                    end
                    default:
                    begin
                        cmd.capture  = 1'b1;
                        cmd.res_kind = RES_ZERO;
                        state_next   = ST_HOLD;
                    end
                endcase
            end
            ST_HOLD:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.push)
            out_valid_next = 1'b1;
        else
            out_valid_next = out_valid_reg && !rsp_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = out_valid_reg;

endmodule

// ===== rtl/wft_datapath.sv =====
// Datapath for the wildcard flow table: rule memory, used bits, scan pointer,
// match compare, pending result and output register. Depends on wft_pkg.
module wft_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  wft_pkg::dp_cmd_t                  cmd_in,
    output wft_pkg::dp_stat_t                 stat,
    input  logic [wft_pkg::CMD_W-1:0]         cmd,
    input  logic [wft_pkg::IP_W-1:0]          src_ip,
    input  logic [wft_pkg::IP_W-1:0]          dst_ip,
    input  logic [wft_pkg::L4_PORT_W-1:0]     src_port,
    input  logic [wft_pkg::L4_PORT_W-1:0]     dst_port,
    input  logic [wft_pkg::PROTO_W-1:0]       protocol,
    input  logic [wft_pkg::ACTION_W-1:0]      rule_action,
    input  logic [wft_pkg::OUT_PORT_W-1:0]    rule_port,
    output logic                              hit,
    output logic [wft_pkg::ENTRY_IDX_W-1:0]   entry_index,
    output logic [wft_pkg::ACTION_W-1:0]      match_action,
    output logic [wft_pkg::OUT_PORT_W-1:0]    match_port,
    output logic                              table_full
);
    import wft_pkg::*;

    rule_t rule_mem [ENTRIES];
    logic  [ENTRIES-1:0] used_reg;

    cmd_t  op_reg;
    rule_t key_reg;
    logic  [IDX_W:0] cnt_reg, cnt_next;

    // read stage
    rule_t            rd_data_reg;
    logic             rd_valid_reg;
    logic             rd_used_reg;
    logic [IDX_W-1:0] rd_idx_reg;

    // pending result
    logic                   res_hit_reg;
    logic [ENTRY_IDX_W-1:0] res_idx_reg;
    logic [ACTION_W-1:0]    res_act_reg;
    logic [OUT_PORT_W-1:0]  res_port_reg;
    logic                   res_full_reg;

    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] ins_addr;
    logic             issue;
    logic             fields_ok;

    assign rd_addr  = cnt_reg[IDX_W-1:0];
    assign ins_addr = (op_reg == CMD_INS_BACK) ? (LAST_IDX - cnt_reg[IDX_W-1:0])
                                               : cnt_reg[IDX_W-1:0];
    assign issue    = cmd_in.step && (op_reg == CMD_LOOKUP) && !cnt_reg[IDX_W];

    assign fields_ok =
        ((rd_data_reg.src_ip   == key_reg.src_ip)   || (rd_data_reg.src_ip   == WILD_IP))   &&
        ((rd_data_reg.dst_ip   == key_reg.dst_ip)   || (rd_data_reg.dst_ip   == WILD_IP))   &&
        ((rd_data_reg.src_port == key_reg.src_port) || (rd_data_reg.src_port == WILD_PORT)) &&
        ((rd_data_reg.dst_port == key_reg.dst_port) || (rd_data_reg.dst_port == WILD_PORT)) &&
        ((rd_data_reg.protocol == key_reg.protocol) || (rd_data_reg.protocol == WILD_PROTO));

    always_comb
    begin
        stat.op          = op_reg;
        stat.match       = rd_valid_reg && rd_used_reg && fields_ok;
        stat.lookup_last = rd_valid_reg && (rd_idx_reg == LAST_IDX);
        stat.free        = !used_reg[ins_addr];
        stat.ins_last    = (cnt_reg[IDX_W-1:0] == LAST_IDX);
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd_in.load)
            cnt_next = '0;
        else if (cmd_in.step && !cnt_reg[IDX_W])
            cnt_next = cnt_reg + 1'b1;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg     <= '0;
            cnt_reg      <= '0;
            rd_valid_reg <= 1'b0;
            op_reg       <= CMD_LOOKUP;
        end
        else
        begin
            cnt_reg      <= cnt_next;
            rd_valid_reg <= issue;
            if (cmd_in.load)
                op_reg <= cmd_t'(cmd);
            if (cmd_in.write)
                used_reg[ins_addr] <= (key_reg.action != ACT_UNUSED);
        end
    end

    // rule memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd_in.write)
            rule_mem[ins_addr] <= key_reg;
        if (issue)
        begin
            rd_data_reg <= rule_mem[rd_addr];
            rd_used_reg <= used_reg[rd_addr];
            rd_idx_reg  <= rd_addr;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_in.load)
        begin
            key_reg.src_ip   <= src_ip;
            key_reg.dst_ip   <= dst_ip;
            key_reg.src_port <= src_port;
            key_reg.dst_port <= dst_port;
            key_reg.protocol <= protocol;
            key_reg.action   <= rule_action;
            key_reg.port     <= rule_port;
        end
        if (cmd_in.capture)
        begin
            res_hit_reg  <= 1'b0;
            res_idx_reg  <= '0;
            res_act_reg  <= '0;
            res_port_reg <= '0;
            res_full_reg <= 1'b0;
            case (cmd_in.res_kind)
                RES_HIT:
                begin
                    res_hit_reg  <= 1'b1;
                    res_idx_reg  <= ENTRY_IDX_W'(rd_idx_reg);
                    res_act_reg  <= rd_data_reg.action;
                    res_port_reg <= rd_data_reg.port;
                end
                RES_SLOT:
                begin
                    res_idx_reg <= ENTRY_IDX_W'(ins_addr);
                end
                RES_FULL:
                begin
                    res_full_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        if (cmd_in.push)
        begin
            hit          <= res_hit_reg;
            entry_index  <= res_idx_reg;
            match_action <= res_act_reg;
            match_port   <= res_port_reg;
            table_full   <= res_full_reg;
        end
    end

endmodule

// ===== rtl/wildcard_flow_table_unit.sv =====
// Top level of the wildcard five-tuple flow table.
// Depends on wft_pkg, wft_ctrl and wft_datapath.
//
// Usage:
//   Request channel (req_valid/req_ready) carries one word: cmd, the five-tuple
//   key or rule fields, rule_action and rule_port. cmd 0 looks up, 1 inserts
//   into the first unused slot from index 0, 2 inserts from the top index, 3
//   does nothing. Response channel (rsp_valid/rsp_ready) returns one word per
//   request: hit, entry_index, match_action, match_port, table_full.
//   One request is processed at a time. A lookup ends at the first matching
//   entry or after the last entry; an insert ends at the first unused slot
//   or with a full-table answer when no slot is free; cmd 3 returns an all-zero
//   word. The lookup scans the single read port of the rule memory one entry
//   per cycle; the insert walks the used-bit flops one entry per cycle.
//   The response sits in an output register; req_ready returns once the
//   result is staged, so the next request scans while a response waits.
//   If the receiver stalls, the block finishes its scan and then waits.
//   Reset clears all used bits (every slot unused) and the handshakes;
//   rule fields are undefined until written; while unused they reach no response.
module wildcard_flow_table_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  logic [wft_pkg::CMD_W-1:0]         cmd,
    input  logic [wft_pkg::IP_W-1:0]          src_ip,
    input  logic [wft_pkg::IP_W-1:0]          dst_ip,
    input  logic [wft_pkg::L4_PORT_W-1:0]     src_port,
    input  logic [wft_pkg::L4_PORT_W-1:0]     dst_port,
    input  logic [wft_pkg::PROTO_W-1:0]       protocol,
    input  logic [wft_pkg::ACTION_W-1:0]      rule_action,
    input  logic [wft_pkg::OUT_PORT_W-1:0]    rule_port,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output logic                              hit,
    output logic [wft_pkg::ENTRY_IDX_W-1:0]   entry_index,
    output logic [wft_pkg::ACTION_W-1:0]      match_action,
    output logic [wft_pkg::OUT_PORT_W-1:0]    match_port,
    output logic                              table_full
);
    import wft_pkg::*;

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    wft_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .stat      (dp_stat),
        .cmd       (dp_cmd)
    );

    wft_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_in       (dp_cmd),
        .stat         (dp_stat),
        .cmd          (cmd),
        .src_ip       (src_ip),
        .dst_ip       (dst_ip),
        .src_port     (src_port),
        .dst_port     (dst_port),
        .protocol     (protocol),
        .rule_action  (rule_action),
        .rule_port    (rule_port),
        .hit          (hit),
        .entry_index  (entry_index),
        .match_action (match_action),
        .match_port   (match_port),
        .table_full   (table_full)
    );

    // one word in flight: an accepted request always drops ready
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request accepted while previous one in progress");

    // a slot is only written if the insert pointer saw it unused
    a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.write |-> dp_stat.free)
        else $error("rule written into a used slot");

    // a hit always reports a used action and never a full table
    a_hit_used: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && hit) |-> (match_action != ACT_UNUSED) && !table_full)
        else $error("hit response with unused action or full flag");

    // a full-table response has no hit, a zero index and a zero port
    a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && table_full) |-> !hit && (entry_index == '0) && (match_port == '0))
        else $error("full-table response with nonzero fields");

endmodule

// ===== verif/tb_wildcard_flow_table_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for wildcard_flow_table_unit: directed and random lookups and
// inserts, each response checked against a shadow copy of the rule table kept in the bench.
// Depends on wft_pkg and the flow table RTL.
module tb_wildcard_flow_table_unit;
    import wft_pkg::*;

    localparam int RANDOM_WORDS = 1900;
    localparam int MAX_GAP      = 18;
    localparam int REPORT_CAP   = 200;

    // how often a side inserts idle cycles between words
    typedef enum int {
        PACE_NONE  = 0,
        PACE_FULL  = 1,
        PACE_LIGHT = 2
    } pace_t;

    // one response word as the block should return it
    typedef struct packed {
        logic                   hit;
        logic [ENTRY_IDX_W-1:0] entry_index;
        action_t                action;
        logic [OUT_PORT_W-1:0]  port;
        logic                   full;
    } flow_rsp_t;

    logic                   clk;
    logic                   rst_n        = 1'b0;
    logic                   req_valid    = 1'b0;
    logic                   req_ready;
    logic [CMD_W-1:0]       cmd          = '0;
    logic [IP_W-1:0]        src_ip       = '0;
    logic [IP_W-1:0]        dst_ip       = '0;
    logic [L4_PORT_W-1:0]   src_port     = '0;
    logic [L4_PORT_W-1:0]   dst_port     = '0;
    logic [PROTO_W-1:0]     protocol     = '0;
    logic [ACTION_W-1:0]    rule_action  = '0;
    logic [OUT_PORT_W-1:0]  rule_port    = '0;
    logic                   rsp_valid;
    logic                   rsp_ready    = 1'b0;
    logic                   hit;
    logic [ENTRY_IDX_W-1:0] entry_index;
    logic [ACTION_W-1:0]    match_action;
    logic [OUT_PORT_W-1:0]  match_port;
    logic                   table_full;

    // shadow of the rule memory; only entries with a nonzero action are ever compared
    rule_t     flow_rules [ENTRIES];
    // responses predicted at request acceptance, oldest first
    flow_rsp_t table_answers [$];
    int        mismatch_count = 0;
    pace_t     req_pace       = PACE_FULL;
    pace_t     rsp_pace       = PACE_FULL;

    wildcard_flow_table_unit dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Apply one accepted request word to the shadow table and return the response.
    function automatic flow_rsp_t resolve_request(input cmd_t op, input rule_t key);
        flow_rsp_t rsp;
        int        slot;
        rsp  = '0;
        slot = -1;
        case (op)
            CMD_LOOKUP:
            begin
                // scan from the top down so the lowest matching index is the one left
                for (int k = ENTRIES - 1; k >= 0; k--)
                begin
                    if (flow_rules[k].action != ACT_UNUSED
                        && (flow_rules[k].src_ip == key.src_ip
                            || flow_rules[k].src_ip == WILD_IP)
                        && (flow_rules[k].dst_ip == key.dst_ip
                            || flow_rules[k].dst_ip == WILD_IP)
                        && (flow_rules[k].src_port == key.src_port
                            || flow_rules[k].src_port == WILD_PORT)
                        && (flow_rules[k].dst_port == key.dst_port
                            || flow_rules[k].dst_port == WILD_PORT)
                        && (flow_rules[k].protocol == key.protocol
                            || flow_rules[k].protocol == WILD_PROTO))
                        slot = k;
                end
                if (slot >= 0)
                begin
                    rsp.hit         = 1'b1;
                    rsp.entry_index = ENTRY_IDX_W'(slot);
                    rsp.action      = action_t'(flow_rules[slot].action);
                    rsp.port        = flow_rules[slot].port;
                end
            end
            CMD_INS_FRONT, CMD_INS_BACK:
            begin
                // front: keep the first free slot; back: keep overwriting up to the last
                for (int k = 0; k < ENTRIES; k++)
                begin
                    if (flow_rules[k].action == ACT_UNUSED
                        && (op == CMD_INS_BACK || slot < 0))
                        slot = k;
                end
                if (slot >= 0)
                begin
                    flow_rules[slot] = key;
                    rsp.entry_index  = ENTRY_IDX_W'(slot);
                end
                else
                    rsp.full = 1'b1;
            end
            default: ;
        endcase
        return rsp;
    endfunction

    function automatic int draw_gap(input pace_t pace);
        int gap;
        case (pace)
            PACE_NONE: gap = 0;
            PACE_FULL: gap = $urandom_range(MAX_GAP);
            default:   gap = ($urandom_range(7) == 0) ? $urandom_range(MAX_GAP) : 0;
        endcase
        return gap;
    endfunction

    // Field value of width w: wildcard, a collision-prone small value, or anything.
    function automatic logic [31:0] pick_field(input int w);
        logic [31:0] all_ones;
        logic [31:0] v;
        all_ones = 32'hffff_ffff >> (32 - w);
        case ($urandom_range(3))
            0: v = all_ones;
            1: v = ($urandom_range(3) == 3) ? all_ones - 1 : 32'($urandom_range(2));
            default: v = $urandom & all_ones;
        endcase
        return v;
    endfunction

    function automatic rule_t rule_of(input logic [IP_W-1:0] sip, input logic [IP_W-1:0] dip,
                                      input logic [L4_PORT_W-1:0] sp,
                                      input logic [L4_PORT_W-1:0] dp,
                                      input logic [PROTO_W-1:0] pr, input action_t act,
                                      input logic [OUT_PORT_W-1:0] oport);
        rule_t r;
        r.src_ip   = sip;
        r.dst_ip   = dip;
        r.src_port = sp;
        r.dst_port = dp;
        r.protocol = pr;
        r.action   = act;
        r.port     = oport;
        return r;
    endfunction

    function automatic rule_t random_rule();
        return rule_of(pick_field(IP_W), pick_field(IP_W),
                       L4_PORT_W'(pick_field(L4_PORT_W)), L4_PORT_W'(pick_field(L4_PORT_W)),
                       PROTO_W'(pick_field(PROTO_W)), action_t'($urandom_range(3)),
                       OUT_PORT_W'($urandom));
    endfunction

    // Lookup key that satisfies rule r: exact fields copied, wildcard fields random.
    function automatic rule_t key_from_rule(input rule_t r);
        rule_t k;
        k        = r;
        k.action = action_t'($urandom_range(3));
        k.port   = OUT_PORT_W'($urandom);
        if (r.src_ip == WILD_IP)
            k.src_ip = pick_field(IP_W);
        if (r.dst_ip == WILD_IP)
            k.dst_ip = pick_field(IP_W);
        if (r.src_port == WILD_PORT)
            k.src_port = L4_PORT_W'(pick_field(L4_PORT_W));
        if (r.dst_port == WILD_PORT)
            k.dst_port = L4_PORT_W'(pick_field(L4_PORT_W));
        if (r.protocol == WILD_PROTO)
            k.protocol = PROTO_W'(pick_field(PROTO_W));
        return k;
    endfunction

    // Mostly lookups aimed at live rules, some near misses, sparse inserts so the
    // table fills over the course of the run, and a few no-op words.
    function automatic void random_request(output cmd_t op, output rule_t fields);
        int used_idx [$];
        int roll;
        roll = $urandom_range(99);
        for (int k = 0; k < ENTRIES; k++)
            if (flow_rules[k].action != ACT_UNUSED)
                used_idx.push_back(k);
        op     = CMD_LOOKUP;
        fields = random_rule();
        if (roll < 3)
            op = CMD_NOP;
        else if (roll < 11)
            op = $urandom_range(1) ? CMD_INS_FRONT : CMD_INS_BACK;
        else if (used_idx.size() > 0 && $urandom_range(3) != 0)
        begin
            fields = key_from_rule(flow_rules[used_idx[$urandom_range(used_idx.size() - 1)]]);
            // near miss: one bit off in one key field
            if ($urandom_range(3) == 0)
            begin
                case ($urandom_range(4))
                    0: fields.src_ip   ^= IP_W'(1) << $urandom_range(IP_W - 1);
                    1: fields.dst_ip   ^= IP_W'(1) << $urandom_range(IP_W - 1);
                    2: fields.src_port ^= L4_PORT_W'(1) << $urandom_range(L4_PORT_W - 1);
                    3: fields.dst_port ^= L4_PORT_W'(1) << $urandom_range(L4_PORT_W - 1);
                    default: fields.protocol ^= PROTO_W'(1) << $urandom_range(PROTO_W - 1);
                endcase
            end
        end
    endfunction

    // Drive one request word and hold it until accepted. Valid is only dropped when an
    // idle gap follows, so back-to-back words never see a low-high glitch in one step.
    task automatic send_request(input cmd_t op, input rule_t fields);
        int gap;
        gap = draw_gap(req_pace);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid   <= 1'b1;
        cmd         <= op;
        src_ip      <= fields.src_ip;
        dst_ip      <= fields.dst_ip;
        src_port    <= fields.src_port;
        dst_port    <= fields.dst_port;
        protocol    <= fields.protocol;
        rule_action <= fields.action;
        rule_port   <= fields.port;
        @(posedge clk);
        while (req_ready !== 1'b1)
            @(posedge clk);
        table_answers.push_back(resolve_request(op, fields));
    endtask

    // Lookups and no-op on an empty table, including the all-zero and all-ones keys.
    task automatic test_empty_table();
        send_request(CMD_LOOKUP, rule_of('0, '0, '0, '0, '0, ACT_UNUSED, '0));
        send_request(CMD_LOOKUP, rule_of('1, '1, '1, '1, '1, ACT_DROP, '1));
        send_request(CMD_NOP, rule_of('1, '1, '1, '1, '1, ACT_DROP, '1));
    endtask

    // Exact rule at the front, wildcard rule at the back, single-field misses.
    task automatic test_exact_and_wildcard();
        rule_t exact;
        rule_t udp_any;
        rule_t key;
        exact = rule_of(32'h0a00_0001, 32'hc0a8_0101, 16'd1234, 16'd80, 8'd6,
                        ACT_FORWARD, 16'd7);
        send_request(CMD_INS_FRONT, exact);
        send_request(CMD_LOOKUP, exact);
        key          = exact;
        key.dst_port = 16'd81;
        send_request(CMD_LOOKUP, key);
        key        = exact;
        key.src_ip = exact.src_ip ^ 32'h8000_0000;
        send_request(CMD_LOOKUP, key);
        // every field wild but protocol, so misses stay possible later on
        udp_any = rule_of(WILD_IP, WILD_IP, WILD_PORT, WILD_PORT, 8'd17, ACT_DROP, 16'hffff);
        send_request(CMD_INS_BACK, udp_any);
        key = rule_of($urandom, $urandom, L4_PORT_W'($urandom), L4_PORT_W'($urandom), 8'd17,
                      ACT_FORWARD, OUT_PORT_W'($urandom));
        send_request(CMD_LOOKUP, key);
        key.protocol = 8'd16;
        send_request(CMD_LOOKUP, key);
    endtask

    // A rule inserted with action zero is written into a slot but stays invisible, and the slot stays free.
    task automatic test_unused_action();
        rule_t parked;
        parked = rule_of(32'h0, 32'h0, 16'h0, 16'h0, 8'd17, ACT_UNUSED, 16'h1);
        send_request(CMD_INS_FRONT, parked);
        send_request(CMD_LOOKUP, parked);
        parked.action = ACT_REPLY;
        send_request(CMD_INS_FRONT, parked);
        send_request(CMD_LOOKUP, parked);
    endtask

    // Near-wildcard values, protocol wildcard, all-ones keys.
    task automatic test_field_extremes();
        rule_t any_proto;
        rule_t near_wild;
        rule_t key;
        any_proto = rule_of(32'hffff_fffe, 32'h0, 16'hfffe, 16'h0, WILD_PROTO, ACT_DROP, 16'h0);
        send_request(CMD_INS_BACK, any_proto);
        key          = any_proto;
        key.protocol = 8'h00;
        send_request(CMD_LOOKUP, key);
        key.protocol = 8'hff;
        send_request(CMD_LOOKUP, key);
        near_wild = rule_of(WILD_IP, 32'hffff_fffe, WILD_PORT, 16'hfffe, 8'hfe,
                            ACT_FORWARD, 16'hffff);
        send_request(CMD_INS_FRONT, near_wild);
        send_request(CMD_LOOKUP, rule_of('1, 32'hffff_fffe, '1, 16'hfffe, 8'hfe,
                                         ACT_UNUSED, '0));
        send_request(CMD_LOOKUP, rule_of('1, '1, '1, '1, '1, ACT_REPLY, '1));
        send_request(CMD_NOP, random_rule());
    endtask

    // Bulk traffic; both sides switch pacing every hundred words.
    task automatic test_random_traffic();
        cmd_t  op;
        rule_t fields;
        int    sent;
        int    iter;
        sent = 0;
        iter = 0;
        while (sent < RANDOM_WORDS)
        begin
            if (iter % 100 == 0)
            begin
                req_pace = pace_t'($urandom_range(2));
                rsp_pace = pace_t'($urandom_range(2));
            end
            random_request(op, fields);
            send_request(op, fields);
            if (op != CMD_NOP)
                sent++;
            iter++;
        end
    endtask

    // Fill whatever is left, then inserts from both ends must report a full table.
    task automatic test_full_table();
        rule_t fields;
        bit    free_left;
        req_pace  = PACE_FULL;
        rsp_pace  = PACE_LIGHT;
        free_left = 1'b1;
        while (free_left)
        begin
            free_left = 1'b0;
            foreach (flow_rules[k])
                if (flow_rules[k].action == ACT_UNUSED)
                    free_left = 1'b1;
            if (free_left)
            begin
                fields = random_rule();
                if (fields.action == ACT_UNUSED)
                    fields.action = ACT_FORWARD;
                send_request($urandom_range(1) ? CMD_INS_FRONT : CMD_INS_BACK, fields);
            end
        end
        for (int n = 0; n < 6; n++)
            send_request(n[0] ? CMD_INS_BACK : CMD_INS_FRONT, random_rule());
        for (int n = 0; n < 4; n++)
            send_request(CMD_LOOKUP, key_from_rule(flow_rules[$urandom_range(ENTRIES - 1)]));
        send_request(CMD_NOP, random_rule());
    endtask

    // Response side: random ready gaps, each accepted word compared with the oldest
    // prediction. A word arriving with nothing outstanding is a failure too.
    initial
    begin : rsp_checker
        flow_rsp_t want;
        int        gap;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = draw_gap(rsp_pace);
            if (gap > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            @(posedge clk);
            while (rsp_valid !== 1'b1)
                @(posedge clk);
            if (table_answers.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_CAP)
                    $display("%0t: unexpected word, expected none, got %0d/%0d/%0d/%h/%0d",
                             $time, hit, entry_index, match_action, match_port, table_full);
            end
            else
            begin
                want = table_answers.pop_front();
                if (hit !== want.hit || entry_index !== want.entry_index
                    || match_action !== want.action || match_port !== want.port
                    || table_full !== want.full)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_CAP)
                        $display("%0t: hit/idx/act/port/full expected %0d/%0d/%0d/%h/%0d, got %0d/%0d/%0d/%h/%0d",
                                 $time, want.hit, want.entry_index, want.action, want.port,
                                 want.full, hit, entry_index, match_action, match_port,
                                 table_full);
                end
            end
        end
    end

    // Main sequence: reset, directed tests, random traffic, full-table tail, drain.
    initial
    begin
        foreach (flow_rules[k])
            flow_rules[k] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_exact_and_wildcard();
        test_unused_action();
        test_field_extremes();
        test_random_traffic();
        test_full_table();
        req_valid <= 1'b0;

        // drain, then idle past a full scan so any stray word would show
        while (table_answers.size() != 0)
            @(posedge clk);
        repeat (ENTRIES + 8) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog: stops a hung run and reports an error.
    initial
    begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/wft_pkg.sv
rtl/wft_ctrl.sv
rtl/wft_datapath.sv
rtl/wildcard_flow_table_unit.sv
verif/tb_wildcard_flow_table_unit.sv
